/* hdl/ptgm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgm_pkg
// Shared widths, codes, types and helpers of the point to grid map rasterizer.
// ----------------------------------------------------------------------------
package ptgm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int COORD_W = 16;
  localparam int INV_W   = 17;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 10;
  localparam int MODE_W  = 3;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = INV_W;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + INV_W + 1;
  localparam int MAG_W   = PROD_W - 1;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = MAG_W + 1 - FRAC_W;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_FLOOR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OBST  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROOF  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } cell_pos_t;

  // round(prod / 2^16), half away from zero, magnitude only
  function automatic logic [QUO_W-1:0] round_mag(input logic signed [PROD_W-1:0] prod);
    logic [MAG_W-1:0] mag;
    logic [MAG_W:0]   sum;
    begin
      mag = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
      sum = {1'b0, mag} + (MAG_W+1)'(1 << (FRAC_W - 1));
      round_mag = sum[MAG_W:FRAC_W];
    end
  endfunction

endpackage

/* hdl/ptgm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgm_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module ptgm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/ptgm_proj.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgm_proj
// Two stage projection of a point onto a map cell: multiply by the Q16
// reciprocal, then round, range check and flip the row.
// ----------------------------------------------------------------------------
module ptgm_proj (
  input  logic                           clk,
  input  logic signed [ptgm_pkg::COORD_W-1:0] x_mm,
  input  logic signed [ptgm_pkg::COORD_W-1:0] y_mm,
  input  logic signed [ptgm_pkg::COORD_W-1:0] min_x_mm,
  input  logic signed [ptgm_pkg::COORD_W-1:0] min_y_mm,
  input  logic [ptgm_pkg::INV_W-1:0]     inv_cell_q16,
  input  logic [ptgm_pkg::DIM_W-1:0]     w_eff,
  input  logic [ptgm_pkg::DIM_W-1:0]     h_eff,
  output ptgm_pkg::cell_pos_t            pos
);
  import ptgm_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] inv_s;
  logic signed [PROD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [QUO_W-1:0]         qx, qy;
  logic                     ok_x, ok_y;
  logic [DIM_W-1:0]         row_full;
  cell_pos_t                pos_r, pos_nxt;

  always_comb begin
    dx     = DIFF_W'(x_mm) - DIFF_W'(min_x_mm);
    dy     = DIFF_W'(y_mm) - DIFF_W'(min_y_mm);
    inv_s  = $signed(PROD_W'(inv_cell_q16));
    px_nxt = PROD_W'(dx) * inv_s;
    py_nxt = PROD_W'(dy) * inv_s;
  end

  always_comb begin
    qx   = round_mag(px_r);
    qy   = round_mag(py_r);
    ok_x = (!px_r[PROD_W-1] || (qx == '0)) && (qx < QUO_W'(w_eff));
    ok_y = (!py_r[PROD_W-1] || (qy == '0)) && (qy < QUO_W'(h_eff));
    row_full       = h_eff - DIM_W'(1) - qy[DIM_W-1:0];
    pos_nxt.hit    = ok_x && ok_y;
    pos_nxt.col    = qx[POS_W-1:0];
    pos_nxt.row    = row_full[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pos_r <= pos_nxt;
  end

  assign pos = pos_r;

endmodule

/* hdl/point_to_grid_map_rasterizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_grid_map_rasterizer_unit
// Projects classified points onto a 1024 x 1024 RGB grid map in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens at a clock edge with start high and
//   busy low. in_mode selects floor, obstacle, roof/marker point, read cell or
//   clear map. Config writes (cfg_we, cfg_index, cfg_wdata) go in while idle.
//   Result channel: out_valid is high for one cycle with the cell fields;
//   the receiver cannot stall, so each result must be taken that cycle.
//   Sequence: a point or read transfer steps through ST_MUL, ST_IDX, ST_RD
//   and ST_WB with busy high; out_valid rises as busy falls. No new item is
//   taken while busy. Busy covers the read-modify-write through the single
//   RAM port plus the two stage multiply and round of the projection.
//   Clear command: the store is zeroed one cell per cycle over all 1048576
//   cells, then a single all zero result is given.
//   Reset: config returns to its defaults and the same clear of all cells
//   runs with busy high; no result is given for it.
// ----------------------------------------------------------------------------
module point_to_grid_map_rasterizer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptgm_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [ptgm_pkg::COORD_W-1:0] in_x_mm,
  input  logic signed [ptgm_pkg::COORD_W-1:0] in_y_mm,
  input  logic [ptgm_pkg::POS_W-1:0]          in_read_col,
  input  logic [ptgm_pkg::POS_W-1:0]          in_read_row,
  output logic                                out_valid,
  output logic                                out_in_map,
  output logic [ptgm_pkg::POS_W-1:0]          out_cell_col,
  output logic [ptgm_pkg::POS_W-1:0]          out_cell_row,
  output logic [ptgm_pkg::CHAN_W-1:0]         out_red,
  output logic [ptgm_pkg::CHAN_W-1:0]         out_green,
  output logic [ptgm_pkg::CHAN_W-1:0]         out_blue,
  input  logic                                cfg_we,
  input  logic [ptgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptgm_pkg::CFG_W-1:0]          cfg_wdata
);
  import ptgm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_IDX  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic signed [COORD_W-1:0] min_x_r, min_y_r;
  logic [INV_W-1:0]          inv_r;
  logic [DIM_W-1:0]          map_w_r, map_h_r;
  logic [DIM_W-1:0]          w_eff, h_eff;

  logic [MODE_W-1:0]         mode_r, mode_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [POS_W-1:0]          rc_r, rc_nxt, rr_r, rr_nxt;

  logic [ADDR_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic                      report_r, report_nxt;

  cell_pos_t                 ppos;
  cell_pos_t                 sel_r, sel_nxt;
  logic [ADDR_W-1:0]         addr_r, addr_nxt;
  logic                      is_point_r, is_point;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [PIX_W-1:0]          ram_wdata, ram_rdata;
  logic [PIX_W-1:0]          cell_new, cell_out;

  logic                      ov_r, ov_nxt;
  logic                      om_r, om_nxt;
  logic [POS_W-1:0]          oc_r, oc_nxt, or_r, or_nxt;
  logic [PIX_W-1:0]          opix_r, opix_nxt;

  assign w_eff = (map_w_r > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : map_w_r;
  assign h_eff = (map_h_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_h_r;

  ptgm_proj u_proj (
    .clk          (clk),
    .x_mm         (x_r),
    .y_mm         (y_r),
    .min_x_mm     (min_x_r),
    .min_y_mm     (min_y_r),
    .inv_cell_q16 (inv_r),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .pos          (ppos)
  );

  ptgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign is_point = (mode_r inside {MODE_FLOOR, MODE_OBST, MODE_ROOF});

  always_comb begin
    case (mode_r)
      MODE_FLOOR: cell_new = {ram_rdata[23:16], CHAN_FULL, ram_rdata[7:0]};
      MODE_OBST:  cell_new = {CHAN_FULL, 1'b0, ram_rdata[15:9], ram_rdata[7:0]};
      default:    cell_new = {ram_rdata[23:8], CHAN_FULL};
    endcase
    cell_out = is_point_r ? cell_new : ram_rdata;
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    rc_nxt       = rc_r;
    rr_nxt       = rr_r;
    clr_addr_nxt = clr_addr_r;
    report_nxt   = report_r;
    sel_nxt      = sel_r;
    addr_nxt     = addr_r;
    ram_we       = 1'b0;
    ram_addr     = addr_r;
    ram_wdata    = cell_new;
    ov_nxt       = 1'b0;
    om_nxt       = 1'b0;
    oc_nxt       = '0;
    or_nxt       = '0;
    opix_nxt     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          x_nxt    = in_x_mm;
          y_nxt    = in_y_mm;
          rc_nxt   = in_read_col;
          rr_nxt   = in_read_row;
          if (in_mode == MODE_CLEAR) begin
            clr_addr_nxt = '0;
            report_nxt   = 1'b1;
            state_nxt    = ST_CLR;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: state_nxt = ST_IDX;
      ST_IDX: state_nxt = ST_RD;
      ST_RD: begin
        if (is_point) begin
          sel_nxt = ppos;
        end else if (mode_r == MODE_READ) begin
          sel_nxt.hit    = ({1'b0, rc_r} < w_eff) && ({1'b0, rr_r} < h_eff);
          sel_nxt.col    = rc_r;
          sel_nxt.row    = rr_r;
        end else begin
          sel_nxt = '0;
        end
        addr_nxt  = ADDR_W'(ADDR_W'(sel_nxt.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sel_nxt.col));
        ram_addr  = addr_nxt;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        ram_we = is_point_r && sel_r.hit;
        ov_nxt = 1'b1;
        if (sel_r.hit) begin
          om_nxt   = 1'b1;
          oc_nxt   = sel_r.col;
          or_nxt   = sel_r.row;
          opix_nxt = cell_out;
        end
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          ov_nxt     = report_r;
          report_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      report_r   <= 1'b0;
      ov_r       <= 1'b0;
      min_x_r    <= -16'sd3000;
      min_y_r    <= '0;
      inv_r      <= 17'd6554;
      map_w_r    <= 11'd600;
      map_h_r    <= 11'd600;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      report_r   <= report_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_X:  min_x_r <= cfg_wdata[COORD_W-1:0];
          CFG_MIN_Y:  min_y_r <= cfg_wdata[COORD_W-1:0];
          CFG_INV:    inv_r   <= cfg_wdata[INV_W-1:0];
          CFG_WIDTH:  map_w_r <= cfg_wdata[DIM_W-1:0];
          CFG_HEIGHT: map_h_r <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    rc_r       <= rc_nxt;
    rr_r       <= rr_nxt;
    sel_r      <= sel_nxt;
    addr_r     <= addr_nxt;
    is_point_r <= is_point;
    om_r       <= om_nxt;
    oc_r       <= oc_nxt;
    or_r       <= or_nxt;
    opix_r     <= opix_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = ov_r;
  assign out_in_map   = om_r;
  assign out_cell_col = oc_r;
  assign out_cell_row = or_r;
  assign out_red      = opix_r[23:16];
  assign out_green    = opix_r[15:8];
  assign out_blue     = opix_r[7:0];

endmodule

/* hdl/ptgm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgm_checker
// Port level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module ptgm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic                                out_in_map,
  input logic [ptgm_pkg::POS_W-1:0]          out_cell_col,
  input logic [ptgm_pkg::POS_W-1:0]          out_cell_row,
  input logic [ptgm_pkg::CHAN_W-1:0]         out_red,
  input logic [ptgm_pkg::CHAN_W-1:0]         out_green,
  input logic [ptgm_pkg::CHAN_W-1:0]         out_blue
);
  import ptgm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("store clear not started after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer taken without going busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_map |-> (out_cell_col == '0) && (out_cell_row == '0) &&
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("outside result carries nonzero fields");

endmodule

bind point_to_grid_map_rasterizer_unit ptgm_checker u_ptgm_checker (.*);

/* bench/point_to_grid_map_rasterizer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_grid_map_rasterizer_unit_tb
// Drives floor, obstacle, roof, read, clear and unused commands into the grid
// map rasterizer under a series of map setups. A projection model with its
// own pixel map predicts every result, which is then compared field by field.
// ----------------------------------------------------------------------------
module point_to_grid_map_rasterizer_unit_tb;
  import ptgm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = MODE_CLEAR + 3'd1;
  localparam int ITEMS_PER_PHASE = 126;
  localparam int NUM_PHASES = 10;

  typedef struct packed {
    logic              in_map;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } cell_result_t;

  class grid_map_scoreboard;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic [INV_W-1:0]          inv;
    logic [DIM_W-1:0]          width_cells;
    logic [DIM_W-1:0]          height_cells;
    bit [PIX_W-1:0]            pix [int unsigned];
    cell_result_t              awaited_cells[$];
    int unsigned               mismatches;

    function new();
      min_x        = -16'sd3000;
      min_y        = '0;
      inv          = 17'd6554;
      width_cells  = 11'd600;
      height_cells = 11'd600;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_MIN_X:  min_x = data[COORD_W-1:0];
        CFG_MIN_Y:  min_y = data[COORD_W-1:0];
        CFG_INV:    inv = data[INV_W-1:0];
        CFG_WIDTH:  width_cells = data[DIM_W-1:0];
        CFG_HEIGHT: height_cells = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] d, int unsigned limit);
      return (d > limit) ? limit : int'(d);
    endfunction

    // round half away from zero of (c - lo) * inv / 2^16
    function longint cell_index(logic signed [COORD_W-1:0] c,
                                logic signed [COORD_W-1:0] lo);
      longint p, m, q;
      p = (longint'(c) - longint'(lo)) * longint'(inv);
      m = (p < 0) ? -p : p;
      q = (m + 32768) >> 16;
      return (p < 0) ? -q : q;
    endfunction

    function bit [PIX_W-1:0] pixel_at(int unsigned addr);
      return pix.exists(addr) ? pix[addr] : '0;
    endfunction

    function void project_command(logic [MODE_W-1:0] mode,
                                  logic signed [COORD_W-1:0] x,
                                  logic signed [COORD_W-1:0] y,
                                  logic [POS_W-1:0] rc, logic [POS_W-1:0] rr);
      int unsigned  w, h, row, addr;
      longint       cx, cy;
      bit [PIX_W-1:0] cellv;
      cell_result_t r;
      w = eff_dim(width_cells, MAX_WIDTH);
      h = eff_dim(height_cells, MAX_HEIGHT);
      r = '0;
      case (mode)
        MODE_FLOOR, MODE_OBST, MODE_ROOF: begin
          cx = cell_index(x, min_x);
          cy = cell_index(y, min_y);
          if (cx >= 0 && cx < w && cy >= 0 && cy < h) begin
            row = h - 1 - int'(cy);
            addr = row * MAX_WIDTH + int'(cx);
            cellv = pixel_at(addr);
            if (mode == MODE_FLOOR) begin
              cellv[15:8] = CHAN_FULL;
            end else if (mode == MODE_OBST) begin
              cellv[23:16] = CHAN_FULL;
              cellv[15:8] = cellv[15:8] >> 1;
            end else begin
              cellv[7:0] = CHAN_FULL;
            end
            pix[addr] = cellv;
            r.in_map = 1'b1;
            r.col = POS_W'(cx);
            r.row = POS_W'(row);
            {r.red, r.green, r.blue} = cellv;
          end
        end
        MODE_READ: begin
          if (rc < w && rr < h) begin
            r.in_map = 1'b1;
            r.col = rc;
            r.row = rr;
            {r.red, r.green, r.blue} = pixel_at(int'(rr) * MAX_WIDTH + int'(rc));
          end
        end
        MODE_CLEAR: pix.delete();
        default: ;
      endcase
      awaited_cells.push_back(r);
    endfunction

    function void log_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void compare_cell(cell_result_t got);
      cell_result_t exp_cell;
      if (awaited_cells.size() == 0) begin
        log_failure($sformatf("result with nothing outstanding: in_map=%0d col=%0d row=%0d",
                              got.in_map, got.col, got.row));
        return;
      end
      exp_cell = awaited_cells.pop_front();
      if (got !== exp_cell)
        log_failure({
          $sformatf("cell mismatch exp in_map=%0d col=%0d row=%0d rgb=%h/%h/%h",
                    exp_cell.in_map, exp_cell.col, exp_cell.row, exp_cell.red,
                    exp_cell.green, exp_cell.blue),
          $sformatf(" got in_map=%0d col=%0d row=%0d rgb=%h/%h/%h",
                    got.in_map, got.col, got.row, got.red, got.green, got.blue)});
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode;
  logic signed [COORD_W-1:0] in_x_mm;
  logic signed [COORD_W-1:0] in_y_mm;
  logic [POS_W-1:0]          in_read_col;
  logic [POS_W-1:0]          in_read_row;
  logic                      out_valid;
  logic                      out_in_map;
  logic [POS_W-1:0]          out_cell_col;
  logic [POS_W-1:0]          out_cell_row;
  logic [CHAN_W-1:0]         out_red;
  logic [CHAN_W-1:0]         out_green;
  logic [CHAN_W-1:0]         out_blue;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  grid_map_scoreboard sb;
  int unsigned idle_pct;

  point_to_grid_map_rasterizer_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_x_mm      (in_x_mm),
    .in_y_mm      (in_y_mm),
    .in_read_col  (in_read_col),
    .in_read_row  (in_read_row),
    .out_valid    (out_valid),
    .out_in_map   (out_in_map),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.compare_cell({out_in_map, out_cell_col, out_cell_row, out_red, out_green, out_blue});
  end

  // called at a falling edge, returns at a falling edge
  task automatic issue_command(input logic [MODE_W-1:0] mode,
                               input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [POS_W-1:0] rc, input logic [POS_W-1:0] rr);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_x_mm     <= x;
    in_y_mm     <= y;
    in_read_col <= rc;
    in_read_row <= rr;
    do @(posedge clk); while (busy !== 1'b0);
    sb.project_command(mode, x, y, rc, rr);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_map_setup(input int mx, input int my, input int unsigned inv,
                                 input int unsigned w, input int unsigned h);
    start <= 1'b0;
    while (sb.awaited_cells.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    // spare upper bits carry random values, the block keeps only the low bits
    write_reg(CFG_MIN_X,  {1'($urandom), 16'(mx)});
    write_reg(CFG_MIN_Y,  {1'($urandom), 16'(my)});
    write_reg(CFG_INV,    17'(inv));
    write_reg(CFG_WIDTH,  {6'($urandom), 11'(w)});
    write_reg(CFG_HEIGHT, {6'($urandom), 11'(h)});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // coordinate that lands near a random cell index in [-1, cells]
  function automatic logic [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] lo,
                                                    logic [INV_W-1:0] inv,
                                                    int unsigned cells);
    longint t, c;
    t = longint'($urandom_range(0, cells + 1)) - 1;
    c = longint'(lo) + longint'($urandom_range(0, 4)) - 2;
    if (inv != 0) c = c + (t * 65536) / longint'(inv);
    if (c < -32768) c = -32768;
    if (c > 32767) c = 32767;
    return COORD_W'(c);
  endfunction

  task automatic send_random_item(output bit useful);
    int unsigned pick, w, h;
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x, y;
    logic [POS_W-1:0]   rc, rr;
    pick = $urandom_range(0, 99);
    w = sb.eff_dim(sb.width_cells, MAX_WIDTH);
    h = sb.eff_dim(sb.height_cells, MAX_HEIGHT);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    rc = POS_W'($urandom);
    rr = POS_W'($urandom);
    if (pick < 65) begin
      mode = (pick < 30) ? MODE_FLOOR : (pick < 50) ? MODE_OBST : MODE_ROOF;
      if ($urandom_range(0, 4) != 0) begin
        x = near_coord(sb.min_x, sb.inv, w);
        y = near_coord(sb.min_y, sb.inv, h);
      end
    end else if (pick < 88) begin
      mode = MODE_READ;
      if ($urandom_range(0, 4) != 0) begin
        rc = POS_W'($urandom_range(0, (w < 1023) ? w : 1023));
        rr = POS_W'($urandom_range(0, (h < 1023) ? h : 1023));
      end
    end else begin
      mode = MODE_W'(MODE_SPARE + $urandom_range(0, 2));
    end
    useful = (mode <= MODE_READ);
    issue_command(mode, x, y, rc, rr);
  endtask

  initial begin
    int unsigned done_items;
    bit useful;
    sb          = new();
    idle_pct    = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = MODE_FLOOR;
    in_x_mm     = '0;
    in_y_mm     = '0;
    in_read_col = '0;
    in_read_row = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_MIN_X;
    cfg_wdata   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    // the store is walked clear after reset
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);

    // register defaults: left edge of the default map
    issue_command(MODE_FLOOR, -16'sd3000, 16'sd0, '0, '0);

    // half cell per mm, ties round away from zero
    apply_map_setup(0, 0, 32768, 16, 16);
    issue_command(MODE_FLOOR, 16'sd0, 16'sd0, '0, '0);
    issue_command(MODE_OBST, 16'sd0, 16'sd0, '0, '0);
    issue_command(MODE_OBST, 16'sd0, 16'sd0, '0, '0);
    issue_command(MODE_ROOF, 16'sd0, 16'sd0, '0, '0);
    issue_command(MODE_READ, 16'sd0, 16'sd0, 10'd0, 10'd15);
    issue_command(MODE_FLOOR, 16'sd1, 16'sd1, '1, '1);
    issue_command(MODE_FLOOR, -16'sd1, 16'sd0, '0, '0);
    issue_command(MODE_ROOF, 16'sd30, 16'sd30, '0, '0);
    issue_command(MODE_OBST, 16'sd31, 16'sd0, '0, '0);
    issue_command(MODE_FLOOR, 16'h8000, 16'h8000, '0, '0);
    issue_command(MODE_OBST, 16'h7FFF, 16'h7FFF, '1, '1);
    issue_command(MODE_READ, 16'h7FFF, 16'h8000, 10'd15, 10'd0);
    issue_command(MODE_READ, 16'sd0, 16'sd0, 10'd16, 10'd0);
    issue_command(MODE_READ, 16'sd0, 16'sd0, '1, '1);
    issue_command(MODE_SPARE, 16'h7FFF, 16'h7FFF, '1, '1);
    issue_command(MODE_SPARE + 3'd1, 16'h8000, 16'h8000, '1, '0);
    issue_command(MODE_SPARE + 3'd2, 16'sd0, 16'sd0, '0, '1);
    issue_command(MODE_CLEAR, 16'sd0, 16'sd0, '0, '0);
    issue_command(MODE_READ, 16'sd0, 16'sd0, 10'd0, 10'd15);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_map_setup(0, 0, 65536, 8, 8);
        1: apply_map_setup(-3000, 0, 6554, 600, 600);
        2: apply_map_setup(-32768, -32768, 1, 2047, 2047);
        3: apply_map_setup(32767, 32767, 131071, 1024, 1024);
        4: apply_map_setup(-20, 10, 16384, 0, 5);
        5: apply_map_setup($urandom_range(0, 400) - 200, -7, 0, 3, 1);
        6: apply_map_setup(-100, -50, 4096, 20, 12);
        default: begin
          apply_map_setup(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 131071)
                                                      : $urandom_range(512, 32768),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047)
                                                      : $urandom_range(1, 40),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047)
                                                      : $urandom_range(1, 40));
        end
      endcase
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 77 : 27;
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        send_random_item(useful);
        if (useful) done_items++;
      end
    end
    start <= 1'b0;

    while (sb.awaited_cells.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaited_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
